// ===== design/nsep_pkg.sv =====
// ----------------------------------------------------------------------------
// nsep_pkg
// Shared types and constants of the negative sample entity picker.
// ----------------------------------------------------------------------------
package nsep_pkg;

   // opcodes of the request word
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // largest entity count in effect
   localparam logic [16:0] ENTITY_MAX = 17'h10000;

   // row memory depth and anchor slot count
   localparam int TABLE_ROWS   = 65536;
   localparam int ENTITY_SLOTS = 65536;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] anchor;
      logic [11:0] relation;
      logic [15:0] partner;
      logic [15:0] random_fraction;
   } req_word_type;

   typedef struct packed {
      logic [15:0] picked_entity;
      logic [15:0] excluded_count;
   } rsp_word_type;

endpackage

// ===== design/nsep_search.sv =====
// ----------------------------------------------------------------------------
// nsep_search
// Binary search step unit: holds lo and hi bounds and narrows them by one
// compare per memory read.
// ----------------------------------------------------------------------------
module nsep_search #(
   parameter int AW = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AW-1:0] lo_init,
   input  logic [AW-1:0] hi_init,
   input  logic          step,
   input  logic          go_hi,
   output logic [AW-1:0] mid,
   output logic [AW-1:0] lo,
   output logic [AW-1:0] hi,
   output logic          done
);

   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [AW:0]   sum;

   // midpoint of the signed-free offset bounds
   assign sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid  = sum[AW:1];
   assign lo   = lo_ff;
   assign hi   = hi_ff;
   assign done = ({1'b0, lo_ff} + 1'b1) >= {1'b0, hi_ff};

   // bound update
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (start) begin
         lo_in = lo_init;
         hi_in = hi_init;
      end else if (step) begin
         if (go_hi) hi_in = mid;
         else lo_in = mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

endmodule

// ===== design/negative_sample_entity_picker.sv =====
// ----------------------------------------------------------------------------
// negative_sample_entity_picker
// Loads sorted (anchor, relation, partner) rows, then answers queries with an
// entity that is not a partner of the anchor and relation, chosen by rank.
// ----------------------------------------------------------------------------
//  channel | direction | word          | notes
//  req_    | in        | req_word_type | load, query or clear
//  rsp_    | out       | rsp_word_type | one word per query
//  csr_    | in        | entity_count  | write only while idle
//
// A load writes one row and its anchor range; a clear resets the write pointer
// and sweeps the valid bits. A query runs two binary searches over the
// anchor's rows for the relation range, and when k is not zero it may follow
// them with a rank search over that range.
// Reset sweeps the valid bits and no request is taken
// meanwhile. A query waits in its output state while a response word stalls.
// ----------------------------------------------------------------------------
module negative_sample_entity_picker #(
   parameter int RELATION_SLOTS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nsep_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nsep_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [16:0]           csr_data
);

   localparam int RW = $clog2(nsep_pkg::TABLE_ROWS);
   localparam int EW = $clog2(nsep_pkg::ENTITY_SLOTS);
   localparam int PW = RW + 1;
   // search bounds carry an offset of one so first - 1 stays non-negative
   localparam int AW = RW + 2;

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_RNG   = 5'd2;
   localparam logic [4:0] S_RNGW  = 5'd3;
   localparam logic [4:0] S_A     = 5'd4;
   localparam logic [4:0] S_AW    = 5'd5;
   localparam logic [4:0] S_B0    = 5'd6;
   localparam logic [4:0] S_B     = 5'd7;
   localparam logic [4:0] S_BW    = 5'd8;
   localparam logic [4:0] S_MUL   = 5'd9;
   localparam logic [4:0] S_PL    = 5'd10;
   localparam logic [4:0] S_PLW   = 5'd11;
   localparam logic [4:0] S_PR    = 5'd12;
   localparam logic [4:0] S_PRW   = 5'd13;
   localparam logic [4:0] S_DEC   = 5'd14;
   localparam logic [4:0] S_C0    = 5'd15;
   localparam logic [4:0] S_C     = 5'd16;
   localparam logic [4:0] S_CW    = 5'd17;
   localparam logic [4:0] S_OUT   = 5'd18;

   // memories
   logic [27:0]   row_mem   [nsep_pkg::TABLE_ROWS];
   logic [RW-1:0] first_mem [nsep_pkg::ENTITY_SLOTS];
   logic [RW-1:0] last_mem  [nsep_pkg::ENTITY_SLOTS];
   logic          pres_mem  [nsep_pkg::ENTITY_SLOTS];

   logic [4:0]    state_ff, state_in;
   logic [EW-1:0] sweep_ff, sweep_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [16:0]   prev_ff, prev_in;
   logic [16:0]   ecount_ff;
   nsep_pkg::req_word_type q_ff, q_in;
   logic [27:0]   row_rd_ff;
   logic [RW-1:0] first_rd_ff, last_rd_ff;
   logic          pres_rd_ff;
   logic [AW-1:0] ll_ff, ll_in, rr_ff, rr_in;
   logic [16:0]   k_ff, k_in;
   logic [16:0]   idx_ff, idx_in;
   logic [16:0]   pick_ff, pick_in;
   logic [15:0]   pl_ff, pl_in;
   logic          rsp_valid_ff, rsp_valid_in;
   nsep_pkg::rsp_word_type rsp_ff, rsp_in;

   // memory read address and write controls
   logic [RW-1:0] row_raddr;
   logic          row_we, rng_we_first, rng_we_last, pres_we;
   logic [EW-1:0] pres_waddr;
   logic          pres_wdata;

   // search unit
   logic          s_start, s_step, s_go_hi, s_done;
   logic [AW-1:0] s_lo_init, s_hi_init, s_mid, s_lo, s_hi;

   nsep_search #(.AW(AW)) u_search (
      .clock   (clock),
      .reset   (reset),
      .start   (s_start),
      .lo_init (s_lo_init),
      .hi_init (s_hi_init),
      .step    (s_step),
      .go_hi   (s_go_hi),
      .mid     (s_mid),
      .lo      (s_lo),
      .hi      (s_hi),
      .done    (s_done)
   );

   logic          accept;
   logic          load_ok;
   logic [AW-1:0] first_o, last_o;
   logic [11:0]   row_rel;
   logic [15:0]   row_part;
   logic [16:0]   n_eff;
   logic [33:0]   prod;
   logic [AW+1:0] cmp_l, cmp_r;
   logic [AW:0]   k_raw;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign row_rel  = row_rd_ff[27:16];
   assign row_part = row_rd_ff[15:0];
   assign first_o  = {2'b00, first_rd_ff} + 1'b1;
   assign last_o   = {2'b00, last_rd_ff} + 1'b1;
   assign n_eff    = (ecount_ff > nsep_pkg::ENTITY_MAX) ? nsep_pkg::ENTITY_MAX
                                                         : ecount_ff;
   assign prod     = {1'b0, q_ff.random_fraction} * idx_ff;
   // partner(mid) - mid + ll - 1 < idx, rearranged to stay unsigned
   assign cmp_l = {{(AW+2-16){1'b0}}, row_part} + {2'b00, ll_ff};
   assign cmp_r = {{(AW+2-17){1'b0}}, pick_ff} + {2'b00, s_mid} + 1'b1;
   assign k_raw = {1'b0, rr_ff} + 1'b1 - {1'b0, ll_ff};
   assign load_ok = (wp_ff < PW'(nsep_pkg::TABLE_ROWS))
                 && ({1'b0, q_ff.anchor} < 17'(nsep_pkg::ENTITY_SLOTS))
                 && ({5'd0, q_ff.relation} < 17'(RELATION_SLOTS));

   // main sequencer
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      wp_in = wp_ff;
      prev_in = prev_ff;
      q_in = q_ff;
      ll_in = ll_ff;
      rr_in = rr_ff;
      k_in = k_ff;
      idx_in = idx_ff;
      pick_in = pick_ff;
      pl_in = pl_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      row_raddr = s_mid[RW-1:0] - 1'b1;
      row_we = 1'b0;
      rng_we_first = 1'b0;
      rng_we_last = 1'b0;
      pres_we = 1'b0;
      pres_waddr = q_ff.anchor[EW-1:0];
      pres_wdata = 1'b1;
      s_start = 1'b0;
      s_step = 1'b0;
      s_go_hi = 1'b0;
      s_lo_init = '0;
      s_hi_init = '0;
      case (state_ff)
         S_CLR: begin
            pres_we = 1'b1;
            pres_waddr = sweep_ff;
            pres_wdata = 1'b0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == EW'(nsep_pkg::ENTITY_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               q_in = req_word;
               case (req_word.op)
                  nsep_pkg::OP_QUERY: state_in = S_RNG;
                  nsep_pkg::OP_LOAD:  state_in = S_RNGW;
                  nsep_pkg::OP_CLEAR: begin
                     wp_in = '0;
                     prev_in = '1;
                     sweep_in = '0;
                     state_in = S_CLR;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RNGW: begin
            // load: write row and anchor range
            if (load_ok) begin
               row_we = 1'b1;
               rng_we_last = 1'b1;
               if ({1'b0, q_ff.anchor} != prev_ff) begin
                  rng_we_first = 1'b1;
                  pres_we = 1'b1;
               end
               prev_in = {1'b0, q_ff.anchor};
               wp_in = wp_ff + 1'b1;
            end
            state_in = S_IDLE;
         end
         S_RNG: state_in = S_A;   // range and valid read in flight
         S_A: begin
            // first search: lower bound of relation
            k_in = '0;
            ll_in = '0;
            rr_in = '1;
            if (({1'b0, q_ff.anchor} < 17'(nsep_pkg::ENTITY_SLOTS)) && pres_rd_ff) begin
               s_start = 1'b1;
               s_lo_init = first_o - 1'b1;
               s_hi_init = last_o;
               state_in = S_AW;
            end else begin
               state_in = S_MUL;
            end
         end
         S_AW: begin
            if (s_done) begin
               ll_in = s_hi;
               s_start = 1'b1;
               s_lo_init = first_o;
               s_hi_init = last_o + 1'b1;
               state_in = S_B0;
            end else begin
               state_in = S_B;
            end
         end
         S_B: begin
            s_step = 1'b1;
            s_go_hi = (row_rel >= q_ff.relation);
            state_in = S_AW;
         end
         S_B0: begin
            if (s_done) begin
               rr_in = s_lo;
               state_in = S_DEC;
            end else begin
               state_in = S_BW;
            end
         end
         S_BW: begin
            s_step = 1'b1;
            s_go_hi = !(row_rel <= q_ff.relation);
            state_in = S_B0;
         end
         S_DEC: begin
            k_in = k_raw[AW] ? 17'd0 : 17'(k_raw);
            state_in = S_MUL;
         end
         S_MUL: begin
            // idx_ff temporarily holds n - k for the scaling product
            idx_in = n_eff - k_ff;
            pick_in = '0;
            state_in = (k_ff < n_eff) ? S_PL : S_OUT;
         end
         S_PL: begin
            idx_in = {1'b0, prod[31:16]};
            pick_in = {1'b0, prod[31:16]};
            row_raddr = ll_ff[RW-1:0] - 1'b1;
            if (k_ff == '0) state_in = S_OUT;
            else state_in = S_PLW;
         end
         S_PLW: begin
            // partner at ll arrives, read the row at rr
            pl_in = row_part;
            row_raddr = rr_ff[RW-1:0] - 1'b1;
            state_in = S_PR;
         end
         S_PR: begin
            // keep the rr row on the read port for the next compare
            row_raddr = rr_ff[RW-1:0] - 1'b1;
            state_in = S_PRW;
         end
         S_PRW: begin
            if (idx_ff < {1'b0, pl_ff}) begin
               state_in = S_OUT;
            end else if ({{(AW+2-17){1'b0}}, idx_ff} + {2'b00, rr_ff} + 1'b1
                         > {{(AW+2-16){1'b0}}, row_part} + {2'b00, ll_ff}) begin
               pick_in = idx_ff + k_ff;
               state_in = S_OUT;
            end else begin
               s_start = 1'b1;
               s_lo_init = ll_ff;
               s_hi_init = rr_ff + 1'b1;
               state_in = S_C0;
            end
         end
         S_C0: begin
            if (s_done) begin
               pick_in = 17'(idx_ff + s_lo - ll_ff + 1'b1);
               state_in = S_OUT;
            end else begin
               state_in = S_C;
            end
         end
         S_C: state_in = S_CW;
         S_CW: begin
            // pick_ff holds idx during this search
            s_step = 1'b1;
            s_go_hi = !(cmp_l < cmp_r);
            state_in = S_C0;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.picked_entity = pick_ff[15:0];
               rsp_in.excluded_count = (k_ff > 17'hFFFF) ? 16'hFFFF : k_ff[15:0];
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) rsp_valid_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         sweep_ff <= '0;
         wp_ff <= '0;
         prev_ff <= '1;
         ecount_ff <= nsep_pkg::ENTITY_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         wp_ff <= wp_in;
         prev_ff <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) ecount_ff <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      q_ff <= q_in;
      ll_ff <= ll_in;
      rr_ff <= rr_in;
      k_ff <= k_in;
      idx_ff <= idx_in;
      pick_ff <= pick_in;
      pl_ff <= pl_in;
      rsp_ff <= rsp_in;
   end

   // row memory
   always_ff @(posedge clock) begin
      if (row_we) row_mem[wp_ff[RW-1:0]] <= {q_ff.relation, q_ff.partner};
      row_rd_ff <= row_mem[row_raddr];
   end

   // anchor range memories
   always_ff @(posedge clock) begin
      if (rng_we_first) first_mem[q_ff.anchor[EW-1:0]] <= wp_ff[RW-1:0];
      if (rng_we_last) last_mem[q_ff.anchor[EW-1:0]] <= wp_ff[RW-1:0];
      first_rd_ff <= first_mem[q_ff.anchor[EW-1:0]];
      last_rd_ff <= last_mem[q_ff.anchor[EW-1:0]];
   end

   // anchor valid memory
   always_ff @(posedge clock) begin
      if (pres_we) pres_mem[pres_waddr] <= pres_wdata;
      pres_rd_ff <= pres_mem[q_ff.anchor[EW-1:0]];
   end

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_rsp_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response not from output state");
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PW'(nsep_pkg::TABLE_ROWS))
      else $error("write pointer past capacity");

endmodule
